// ===== rtl/core/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, constants and helper functions of the fixed block pool
// allocator: payload structs, status codes, register indexes and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS  = 256;
  localparam int BLOCK_ALIGN = 16;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = IDX_W + 1;

  // Field and register widths fixed by the interface.
  localparam int SIZE_W     = 16;
  localparam int OFFS_W     = 24;
  localparam int BYTES_W    = 16;
  localparam int TOTAL_W    = 9;
  localparam int BSIZE_W    = BYTES_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int ST_W       = 3;

  // Register reset values.
  localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(64);
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(256);

  // Smallest block size and alignment the pool deals in.
  localparam logic [BYTES_W-1:0] MIN_BYTES = BYTES_W'(8);
  localparam logic [SIZE_W-1:0]  MIN_ALIGN = SIZE_W'(8);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BLOCK_BYTES = 1'b0,
    REG_BLOCK_TOTAL = 1'b1
  } cfg_reg_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_TOO_BIG   = 3'd3,
    ST_OFFSET    = 3'd4,
    ST_ALIGN     = 3'd5,
    ST_NULL_FREE = 3'd6
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [SIZE_W-1:0] req_alignment;
    logic [SIZE_W-1:0] req_offset;
    logic [IDX_W-1:0]  free_index;
    logic              free_present;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  block_index;
    logic [OFFS_W-1:0] byte_offset;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  free_left;
  } rsp_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;  // take the request and launch the link read
    logic commit;  // update the list and load the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_full;  // output register holds a beat that is stalled
  } dp_stat_t;

  // Effective number of blocks: zero block size empties the pool.
  function automatic logic [CNT_W-1:0] pool_count(input logic [BYTES_W-1:0] bytes,
                                                  input logic [TOTAL_W-1:0] total);
    logic [CNT_W-1:0] n;
    n = CNT_W'(total);
    if (bytes == '0) begin
      n = '0;
    end else if (total > TOTAL_W'(MAX_BLOCKS)) begin
      n = CNT_W'(MAX_BLOCKS);
    end
    return n;
  endfunction

  // Block size at least MIN_BYTES, rounded up to BLOCK_ALIGN.
  function automatic logic [BSIZE_W-1:0] rounded_size(input logic [BYTES_W-1:0] bytes);
    logic [BSIZE_W-1:0] s;
    s = (bytes < MIN_BYTES) ? BSIZE_W'(MIN_BYTES) : BSIZE_W'(bytes);
    s = s + BSIZE_W'(BLOCK_ALIGN - 1);
    return s & ~BSIZE_W'(BLOCK_ALIGN - 1);
  endfunction

endpackage

// ===== rtl/core/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: takes one request, waits for the link read, then
// commits it once the output register can take the result.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbpa_pkg::dp_stat_t  stat,
  output fbpa_pkg::ctrl_cmd_t cmd
);
  import fbpa_pkg::*;

  fsm_t state_r;
  fsm_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // The result may only land once the output register is free.
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fbpa_dp.sv =====
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: configuration registers, free list (link memory, head, count),
// request checks and the output register.
// ----------------------------------------------------------------------------
module fbpa_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fbpa_pkg::req_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fbpa_pkg::rsp_t                     out_data,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  fbpa_pkg::ctrl_cmd_t                cmd,
  output fbpa_pkg::dp_stat_t                 stat
);
  import fbpa_pkg::*;

  // Configuration and derived values.
  logic [BYTES_W-1:0] bytes_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0]   n_r;
  logic [BSIZE_W-1:0] bsize_r;
  logic [BYTES_W-1:0] bytes_new;
  logic [TOTAL_W-1:0] total_new;
  logic [CNT_W-1:0]   n_new;

  // Free list.
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic                  empty_r, empty_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [MAX_BLOCKS-1:0] vld_r;
  logic [IDX_W:0]        link_mem [MAX_BLOCKS];

  // Request held between accept and commit.
  logic             kind_r;
  logic [ST_W-1:0]  status_r;
  status_t          status_chk;
  logic [IDX_W-1:0] fidx_r;
  logic [IDX_W:0]   rd_link_r;
  logic             rd_vld_r;

  logic                     link_last;
  logic [IDX_W-1:0]         link_next;
  logic                     do_pop;
  logic                     do_push;
  logic [IDX_W+BSIZE_W-1:0] prod;
  logic [SIZE_W-1:0]        align_eff;
  logic                     align_ok;

  logic out_valid_r;
  rsp_t out_data_r;
  rsp_t rsp;

  // Rebuild values for a register write.
  always_comb begin
    bytes_new = bytes_r;
    total_new = total_r;
    case (cfg_reg_t'(cfg_addr))
      REG_BLOCK_BYTES: bytes_new = cfg_wdata;
      REG_BLOCK_TOTAL: total_new = cfg_wdata[TOTAL_W-1:0];
      default: ;
    endcase
    n_new = pool_count(bytes_new, total_new);
  end

  // Request checks, in priority order.
  always_comb begin
    align_eff  = (in_data.req_alignment < MIN_ALIGN) ? MIN_ALIGN : in_data.req_alignment;
    align_ok   = ((align_eff & (align_eff - SIZE_W'(1))) == '0) &&
                 (align_eff <= SIZE_W'(BLOCK_ALIGN));
    status_chk = ST_OK;
    if (in_data.req_type == REQ_FREE) begin
      if (!in_data.free_present || ({1'b0, in_data.free_index} >= n_r)) begin
        status_chk = ST_NULL_FREE;
      end
    end else if (empty_r) begin
      status_chk = ST_EMPTY;
    end else if (in_data.req_size == '0) begin
      status_chk = ST_ZERO_SIZE;
    end else if (BSIZE_W'(in_data.req_size) > bsize_r) begin
      status_chk = ST_TOO_BIG;
    end else if (in_data.req_offset != '0) begin
      status_chk = ST_OFFSET;
    end else if (!align_ok) begin
      status_chk = ST_ALIGN;
    end
  end

  // An entry never written since the last rebuild links to the index below.
  assign link_last = rd_vld_r ? rd_link_r[IDX_W] : (head_r == '0);
  assign link_next = rd_vld_r ? rd_link_r[IDX_W-1:0] : head_r - IDX_W'(1);

  assign do_pop  = cmd.commit && (kind_r == REQ_ALLOC) && (status_r == ST_OK);
  assign do_push = cmd.commit && (kind_r == REQ_FREE) && (status_r == ST_OK);
  assign prod    = (IDX_W+BSIZE_W)'(head_r) * (IDX_W+BSIZE_W)'(bsize_r);

  always_comb begin
    head_nxt  = head_r;
    empty_nxt = empty_r;
    cnt_nxt   = cnt_r;
    if (do_pop) begin
      if (link_last) begin
        empty_nxt = 1'b1;
      end else begin
        head_nxt = link_next;
      end
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end else if (do_push) begin
      head_nxt  = fidx_r;
      empty_nxt = 1'b0;
      if (cnt_r < n_r) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    rsp.granted     = do_pop;
    rsp.block_index = do_pop ? head_r : '0;
    rsp.byte_offset = do_pop ? prod[OFFS_W-1:0] : '0;
    rsp.status      = status_r;
    rsp.free_left   = cnt_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r     <= BYTES_RESET;
      total_r     <= TOTAL_RESET;
      n_r         <= pool_count(BYTES_RESET, TOTAL_RESET);
      bsize_r     <= rounded_size(BYTES_RESET);
      head_r      <= IDX_W'(pool_count(BYTES_RESET, TOTAL_RESET) - CNT_W'(1));
      empty_r     <= (pool_count(BYTES_RESET, TOTAL_RESET) == '0);
      cnt_r       <= pool_count(BYTES_RESET, TOTAL_RESET);
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bytes_r <= bytes_new;
        total_r <= total_new;
        n_r     <= n_new;
        bsize_r <= rounded_size(bytes_new);
        head_r  <= (n_new == '0) ? '0 : IDX_W'(n_new - CNT_W'(1));
        empty_r <= (n_new == '0);
        cnt_r   <= n_new;
        vld_r   <= '0;
      end else begin
        head_r  <= head_nxt;
        empty_r <= empty_nxt;
        cnt_r   <= cnt_nxt;
        if (do_push) begin
          vld_r[fidx_r] <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Link memory with registered read.
  always_ff @(posedge clk) begin
    if (do_push) begin
      link_mem[fidx_r] <= {empty_r, head_r};
    end
    if (cmd.accept) begin
      rd_link_r <= link_mem[head_r];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_data.req_type;
      status_r <= status_chk;
      fidx_r   <= in_data.free_index;
      rd_vld_r <= vld_r[head_r];
    end
    if (cmd.commit) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.out_full = out_valid_r && out_stall;

endmodule

// ===== rtl/core/fixed_block_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Pool of equal-sized blocks handed out from a last-in-first-out free list.
//
//   Channel  Direction  Handshake            Beat contents
//   in_      input      in_valid / in_stall   req_t: allocate or free request
//   out_     output     out_valid / out_stall rsp_t: grant, offset, status
//   cfg_     input      cfg_we               cfg_addr selects the register
//
// Accepting a request reads the next link of the head from the link memory;
// committing it updates the list and loads the output register.
// While a result waits in the output register, the next request is still
// taken and its link read; it commits once the waiting beat has gone.
// Reset and every register write rebuild a fresh list at once: per-entry
// valid bits are cleared, so there is no clearing pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fbpa_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fbpa_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fbpa_pkg::*;

  // Commands from the sequencer and the back-pressure status it watches.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  // A request is never taken and committed in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in the same cycle");

  // Once a request is taken, the input side is held off for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("input taken while a request is in flight");

  // Every commit presents a result beat.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without an output beat");

  // A granted block always carries the success status.
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.granted) |-> (out_data.status == ST_OK))
    else $error("grant with a failure status");

endmodule
